// ----- rtl/lrust_pkg.sv -----
// ----------------------------------------------------------------------------
// lrust_pkg
// Shared types and sizes for the LRU recency stack of the TLB.
// ----------------------------------------------------------------------------
package lrust_pkg;

  localparam int unsigned Entries  = 4;
  localparam int unsigned TagBits  = 20;
  localparam int unsigned PosW     = $clog2(Entries);
  localparam int unsigned PosBits  = 2;
  localparam int unsigned EvTagBits = 20;

  typedef logic [TagBits-1:0]   tag_t;
  typedef logic [PosW-1:0]      pos_t;
  typedef logic [PosBits-1:0]   hit_pos_t;
  typedef logic [EvTagBits-1:0] ev_tag_t;

  typedef struct packed {
    logic valid;
    tag_t tag;
  } entry_t;

  typedef struct packed {
    logic en;
    logic miss;
  } ctl_t;

endpackage

// ----- rtl/lrust_req_if.sv -----
// ----------------------------------------------------------------------------
// lrust_req_if
// Lookup channel: one page tag per word.
// ----------------------------------------------------------------------------
interface lrust_req_if;
  import lrust_pkg::*;

  logic valid;
  logic ready;
  tag_t page_tag;

  modport source (output valid, output page_tag, input ready);
  modport sink (input valid, input page_tag, output ready);
endinterface

// ----- rtl/lrust_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lrust_rsp_if
// Result channel: hit flag, hit position and evicted tag per word.
// ----------------------------------------------------------------------------
interface lrust_rsp_if;
  import lrust_pkg::*;

  logic     valid;
  logic     ready;
  logic     hit;
  hit_pos_t hit_position;
  logic     evicted_valid;
  ev_tag_t  evicted_tag;

  modport source (output valid, output hit, output hit_position, output evicted_valid,
                  output evicted_tag, input ready);
  modport sink (input valid, input hit, input hit_position, input evicted_valid,
                input evicted_tag, output ready);
endinterface

// ----- rtl/lrust_cell.sv -----
// ----------------------------------------------------------------------------
// lrust_cell
// One recency slot: holds a tag, compares it with the lookup, and takes the
// entry of its upper neighbor when the stack shifts through it.
// ----------------------------------------------------------------------------
module lrust_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lrust_pkg::ctl_t   ctl_i,
  input  lrust_pkg::tag_t   lookup_tag_i,
  input  lrust_pkg::entry_t up_i,
  input  logic            seen_i,
  output lrust_pkg::entry_t entry_o,
  output logic            match_o,
  output logic            seen_o
);
  import lrust_pkg::*;

  logic valid_q;
  tag_t tag_q;
  logic shift;

  assign match_o = valid_q && (tag_q == lookup_tag_i);
  // seen: this cell or one below matched, so this cell takes the entry above it
  assign seen_o  = seen_i | match_o;
  assign shift   = ctl_i.en & (ctl_i.miss | seen_o);

  assign entry_o = '{valid: valid_q, tag: tag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tag_q   <= '0;
    end else if (shift) begin
      valid_q <= up_i.valid;
      tag_q   <= up_i.tag;
    end
  end

endmodule

// ----- rtl/lru_stack_tlb_replacement.sv -----
// ----------------------------------------------------------------------------
// lru_stack_tlb_replacement
// Recency stack of page tags for TLB replacement, built as a row of cells.
// ----------------------------------------------------------------------------
// One lookup word is taken per clock cycle. All cells compare the tag at
// once; the match chain from the least recent cell upward picks the lowest
// match and sets which cells shift, and the stack updates on the accepting
// edge. The result appears in the output register on the next cycle, and a
// new word is taken while the previous result waits; the input stalls only
// when the output register is full and not being drained. Position 0 is the
// least recent entry; empty entries never hit and fill from the top.
// ----------------------------------------------------------------------------
module lru_stack_tlb_replacement (
  input  logic         clk_i,
  input  logic         rst_ni,
  lrust_req_if.sink    req_i,
  lrust_rsp_if.source  rsp_o
);
  import lrust_pkg::*;

  entry_t             ent    [Entries];
  entry_t             up     [Entries];
  logic [Entries-1:0] match;
  logic [Entries:0]   seen;
  logic [Entries-1:0] valid_vec;
  ctl_t               ctl;
  logic               accept;
  logic               hit;
  pos_t               hit_pos;

  logic     rsp_valid_q;
  logic     hit_q;
  hit_pos_t hit_pos_q;
  logic     ev_valid_q;
  ev_tag_t  ev_tag_q;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign seen[0]  = 1'b0;
  assign hit      = seen[Entries];
  assign ctl.en   = accept;
  assign ctl.miss = !hit;

  for (genvar i = 0; i < Entries; i++) begin : g_cell
    if (i == Entries - 1) begin : g_top
      assign up[i] = '{valid: 1'b1, tag: req_i.page_tag};
    end else begin : g_mid
      assign up[i] = ent[i+1];
    end

    assign valid_vec[i] = ent[i].valid;

    lrust_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .lookup_tag_i(req_i.page_tag),
      .up_i        (up[i]),
      .seen_i      (seen[i]),
      .entry_o     (ent[i]),
      .match_o     (match[i]),
      .seen_o      (seen[i+1])
    );
  end

  always_comb begin
    hit_pos = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_pos = pos_t'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q      <= hit;
      hit_pos_q  <= hit ? hit_pos_t'(hit_pos) : '0;
      ev_valid_q <= !hit && ent[0].valid;
      ev_tag_q   <= (!hit && ent[0].valid) ? ev_tag_t'(ent[0].tag) : '0;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.hit           = hit_q;
  assign rsp_o.hit_position  = hit_pos_q;
  assign rsp_o.evicted_valid = ev_valid_q;
  assign rsp_o.evicted_tag   = ev_tag_q;

  // empty slots are always the low end of the stack
  logic [Entries-1:0] empty_vec;
  assign empty_vec = ~valid_vec;

  a_fill_from_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_vec & (empty_vec + 1'b1)) == '0)
    else $error("valid entries not contiguous from the top");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.hit) |-> !rsp_o.evicted_valid)
    else $error("hit reported an eviction");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_o.valid)
    else $error("accepted word produced no result");

  a_top_is_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (ent[Entries-1].valid && ent[Entries-1].tag == $past(req_i.page_tag)))
    else $error("most recent slot does not hold the last lookup");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("tag present in more than one slot");

endmodule
